// ===== hw/rtl/life_cell_stream_step_top_defines.svh =====
// Assertion macros for the life cell stream stepper checker.
// Used by lcs_checker.sv; expects clk and rst_n in the including scope.
`ifndef LIFE_CELL_STREAM_STEP_TOP_DEFINES_SVH
`define LIFE_CELL_STREAM_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lcs_pkg.sv =====
// Shared types, constants and helpers for the life cell stream stepper.
// No dependencies; used by every RTL file of the block.
package lcs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int AGE_BITS   = 8;

    // Fixed field widths of the item and config ports
    localparam int FIELD_AGE_BITS = 8;
    localparam int DIM_BITS       = 11;
    localparam int TOTAL_BITS     = 21;

    // Position counters: row runs up to two past the last row while flushing
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_BITS = ((ROW_BITS > DIM_BITS) ? ROW_BITS : DIM_BITS) + 1;

    localparam int DIM_MIN   = 3;
    localparam int DIM_RESET = 256;

    // Life rule thresholds on the 3x3 count (self included)
    localparam logic [3:0] BIRTH_CNT = 4'd3;
    localparam logic [3:0] DIE_LOW   = 4'd2;
    localparam logic [3:0] DIE_HIGH  = 4'd5;

    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [COL_BITS-1:0] col_t;
    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [TOTAL_BITS-1:0] total_t;

    localparam age_t AGE_MAX = '1;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [FIELD_AGE_BITS-1:0] cell_age;
        logic                      pad;
    } cell_item_t;

    typedef struct packed {
        logic [FIELD_AGE_BITS-1:0] new_age;
        logic                      last_cell;
        total_t                    alive_total;
        total_t                    birth_total;
        total_t                    death_total;
    } result_item_t;

    // Line buffer word: both stored rows of one column
    typedef struct packed {
        age_t upper;
        age_t middle;
    } line_pair_t;

    // Where the window centre sits, for edge masking
    typedef struct packed {
        logic emit;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } win_flags_t;

    function automatic dim_t clamp_dim(input dim_t v, input int hi);
        if (v < dim_t'(DIM_MIN)) begin
            return dim_t'(DIM_MIN);
        end
        if (int'(v) > hi) begin
            return dim_t'(hi);
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/life_cell_stream_step_top.sv =====
// Latency: a cell's result leaves grid_width+1 items after the cell; inside the
// block an emitting item passes the stage 1 registers, then the output register.
// Throughput: 1 item per cycle unless stalled, set by the line buffer's read/write port.
// Reset: position, totals and handshake state clear; grid is 256 x 256; line buffer kept.
// Top level of the life cell stream stepper. Depends on lcs_pkg,
// lcs_pos_ctrl, lcs_line_buf and lcs_stencil.
module life_cell_stream_step_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cell_valid,
    output logic                  cell_ready,
    input  lcs_pkg::cell_item_t   cell_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lcs_pkg::result_item_t result,
    input  logic                  cfg_write,
    input  lcs_pkg::cfg_reg_t     cfg_index,
    input  lcs_pkg::dim_t         cfg_data
);

    logic                accept;
    lcs_pkg::age_t       in_age;
    lcs_pkg::col_t       col;
    lcs_pkg::win_flags_t flags;
    lcs_pkg::line_pair_t rd_data;
    logic                wr_en;
    lcs_pkg::col_t       wr_addr;
    lcs_pkg::line_pair_t wr_data;

    assign accept = cell_valid && cell_ready;

    // Pad items enter as dead cells
    assign in_age = cell_item.pad ? '0 : lcs_pkg::age_t'(cell_item.cell_age);

    lcs_pos_ctrl u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .col       (col),
        .flags     (flags)
    );

    lcs_line_buf u_line (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lcs_stencil u_stencil (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_age       (in_age),
        .in_flags     (flags),
        .in_col       (col),
        .rd_data      (rd_data),
        .restart      (cfg_write),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .ready        (cell_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== hw/rtl/lcs_line_buf.sv =====
// Line buffer memory: one word per column holding the two previous rows.
// Depends on lcs_pkg. One write and one registered read per cycle.
module lcs_line_buf (
    input  logic               clk,
    input  logic               rd_en,
    input  lcs_pkg::col_t      rd_addr,
    output lcs_pkg::line_pair_t rd_data,
    input  logic               wr_en,
    input  lcs_pkg::col_t      wr_addr,
    input  lcs_pkg::line_pair_t wr_data
);

    lcs_pkg::line_pair_t mem [lcs_pkg::MAX_WIDTH];
    lcs_pkg::line_pair_t rd_data_reg;

    // Not cleared: any unwritten entry only reaches masked window taps
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lcs_pos_ctrl.sv =====
// Grid size registers and raster position of the next item.
// Depends on lcs_pkg. Produces the line buffer column and edge flags.
module lcs_pos_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                cfg_write,
    input  lcs_pkg::cfg_reg_t   cfg_index,
    input  lcs_pkg::dim_t       cfg_data,
    output lcs_pkg::col_t       col,
    output lcs_pkg::win_flags_t flags
);

    lcs_pkg::dim_t width_reg;
    lcs_pkg::dim_t height_reg;
    lcs_pkg::col_t col_reg;
    lcs_pkg::col_t col_next;
    logic [lcs_pkg::ROW_BITS-1:0] row_reg;
    logic [lcs_pkg::ROW_BITS-1:0] row_next;

    logic [lcs_pkg::CMP_BITS-1:0] col_ext;
    logic [lcs_pkg::CMP_BITS-1:0] row_ext;
    logic [lcs_pkg::CMP_BITS-1:0] w_ext;
    logic [lcs_pkg::CMP_BITS-1:0] h_ext;
    logic [lcs_pkg::CMP_BITS-1:0] col_inc;
    logic                         col_zero;

    // Edge flags of the cell whose window completes with this item
    always_comb
    begin
        col_ext  = lcs_pkg::CMP_BITS'(col_reg);
        row_ext  = lcs_pkg::CMP_BITS'(row_reg);
        w_ext    = lcs_pkg::CMP_BITS'(width_reg);
        h_ext    = lcs_pkg::CMP_BITS'(height_reg);
        col_zero = (col_reg == '0);

        flags.emit   = (row_ext >= lcs_pkg::CMP_BITS'(2)) ||
                       ((row_ext == lcs_pkg::CMP_BITS'(1)) && !col_zero);
        flags.top    = col_zero ? (row_ext == lcs_pkg::CMP_BITS'(2))
                                : (row_ext == lcs_pkg::CMP_BITS'(1));
        flags.bottom = col_zero ? (row_ext == h_ext + lcs_pkg::CMP_BITS'(1))
                                : (row_ext == h_ext);
        flags.left   = (col_reg == lcs_pkg::COL_BITS'(1));
        flags.right  = col_zero;
        flags.last   = flags.emit && col_zero &&
                       (row_ext == h_ext + lcs_pkg::CMP_BITS'(1));
    end

    // Raster advance, wrapping to a new frame after the last cell
    always_comb
    begin
        col_inc  = col_ext + lcs_pkg::CMP_BITS'(1);
        col_next = lcs_pkg::COL_BITS'(col_inc);
        row_next = row_reg;
        if (col_inc >= w_ext)
        begin
            col_next = '0;
            row_next = lcs_pkg::ROW_BITS'(row_ext + lcs_pkg::CMP_BITS'(1));
        end
        if (flags.last)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lcs_pkg::clamp_dim(lcs_pkg::dim_t'(lcs_pkg::DIM_RESET),
                                             lcs_pkg::MAX_WIDTH);
            height_reg <= lcs_pkg::clamp_dim(lcs_pkg::dim_t'(lcs_pkg::DIM_RESET),
                                             lcs_pkg::MAX_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lcs_pkg::REG_GRID_WIDTH:
                begin
                    width_reg <= lcs_pkg::clamp_dim(cfg_data, lcs_pkg::MAX_WIDTH);
                end
                lcs_pkg::REG_GRID_HEIGHT:
                begin
                    height_reg <= lcs_pkg::clamp_dim(cfg_data, lcs_pkg::MAX_HEIGHT);
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;

endmodule

// ===== hw/rtl/lcs_stencil.sv =====
// Window stage: takes line buffer read data, writes the column back,
// shifts the 3x3 window, applies the life rule and keeps running totals.
// Depends on lcs_pkg.
module lcs_stencil (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  lcs_pkg::age_t         in_age,
    input  lcs_pkg::win_flags_t   in_flags,
    input  lcs_pkg::col_t         in_col,
    input  lcs_pkg::line_pair_t   rd_data,
    input  logic                  restart,
    output logic                  wr_en,
    output lcs_pkg::col_t         wr_addr,
    output lcs_pkg::line_pair_t   wr_data,
    output logic                  ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lcs_pkg::result_item_t result
);

    logic                  s1_valid_reg;
    lcs_pkg::win_flags_t   s1_flags_reg;
    lcs_pkg::age_t         s1_age_reg;
    lcs_pkg::col_t         s1_col_reg;
    lcs_pkg::age_t         win_reg [3][3];
    lcs_pkg::age_t         win_next [3][3];
    logic                  out_valid_reg;
    lcs_pkg::result_item_t out_reg;
    lcs_pkg::total_t       alive_reg;
    lcs_pkg::total_t       birth_reg;
    lcs_pkg::total_t       death_reg;
    lcs_pkg::total_t       alive_next;
    lcs_pkg::total_t       birth_next;
    lcs_pkg::total_t       death_next;
    logic                  s1_move;
    logic [3:0]            cnt;
    lcs_pkg::age_t         self_age;
    lcs_pkg::age_t         nage;

    // Stage 1 advances unless its result is blocked by a full output register
    assign s1_move = s1_valid_reg &&
                     (!s1_flags_reg.emit || !out_valid_reg || result_ready);
    assign ready   = !s1_valid_reg || s1_move;

    // Write back: middle row moves up, new cell becomes middle
    assign wr_en          = s1_move;
    assign wr_addr        = s1_col_reg;
    assign wr_data.upper  = rd_data.middle;
    assign wr_data.middle = s1_age_reg;

    // Shifted window with the new column on the right
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = rd_data.upper;
        win_next[1][2] = rd_data.middle;
        win_next[2][2] = s1_age_reg;
    end

    // Live count over the window, taps outside the grid masked off
    always_comb
    begin
        cnt = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 0) && s1_flags_reg.top) &&
                    !((r == 2) && s1_flags_reg.bottom) &&
                    !((c == 0) && s1_flags_reg.left) &&
                    !((c == 2) && s1_flags_reg.right) &&
                    (win_next[r][c] != '0))
                begin
                    cnt = cnt + 4'd1;
                end
            end
        end
    end

    // Life rule and totals
    always_comb
    begin
        self_age   = win_next[1][1];
        nage       = '0;
        alive_next = alive_reg;
        birth_next = birth_reg;
        death_next = death_reg;
        if (self_age == '0)
        begin
            if (cnt == lcs_pkg::BIRTH_CNT)
            begin
                nage       = lcs_pkg::age_t'(1);
                alive_next = alive_reg + lcs_pkg::total_t'(1);
                birth_next = birth_reg + lcs_pkg::total_t'(1);
            end
        end
        else if ((cnt <= lcs_pkg::DIE_LOW) || (cnt >= lcs_pkg::DIE_HIGH))
        begin
            death_next = death_reg + lcs_pkg::total_t'(1);
        end
        else
        begin
            nage       = (self_age == lcs_pkg::AGE_MAX) ? lcs_pkg::AGE_MAX
                                                        : self_age + lcs_pkg::age_t'(1);
            alive_next = alive_reg + lcs_pkg::total_t'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            alive_reg     <= '0;
            birth_reg     <= '0;
            death_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move && s1_flags_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (restart)
            begin
                alive_reg <= '0;
                birth_reg <= '0;
                death_reg <= '0;
            end
            else if (s1_move && s1_flags_reg.emit)
            begin
                alive_reg <= s1_flags_reg.last ? '0 : alive_next;
                birth_reg <= s1_flags_reg.last ? '0 : birth_next;
                death_reg <= s1_flags_reg.last ? '0 : death_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= in_flags;
            s1_age_reg   <= in_age;
            s1_col_reg   <= in_col;
        end
        if (s1_move)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= win_next[r][c];
                end
            end
        end
        if (s1_move && s1_flags_reg.emit)
        begin
            out_reg.new_age     <= lcs_pkg::FIELD_AGE_BITS'(nage);
            out_reg.last_cell   <= s1_flags_reg.last;
            out_reg.alive_total <= alive_next;
            out_reg.birth_total <= birth_next;
            out_reg.death_total <= death_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hw/rtl/lcs_checker.sv =====
// Port-level checker for the life cell stream stepper, bound to the top.
// Depends on lcs_pkg and life_cell_stream_step_top_defines.svh.
`include "life_cell_stream_step_top_defines.svh"

module lcs_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cell_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input lcs_pkg::result_item_t result
);

    // A stalled item holds
    `LCS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result item changed while stalled")

    // Input only stalls behind a blocked result
    `LCS_ASSERT_NOW(a_ready_only_on_stall, !cell_ready, result_valid && !result_ready, "input stalled without output back-pressure")

    // Births are a subset of live cells
    `LCS_ASSERT_NOW(a_birth_le_alive, result_valid, result.birth_total <= result.alive_total, "birth total exceeds alive total")

    // A live result is counted in the alive total
    `LCS_ASSERT_NOW(a_live_counted, result_valid && (result.new_age != '0), result.alive_total != '0, "live cell missing from alive total")

endmodule

bind life_cell_stream_step_top lcs_checker u_lcs_checker (.*);
